// ===== rtl/skv_pkg.sv =====
// Shared types and codes for the sorted key/value table.
`default_nettype none
package skv_pkg;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE
  } state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic capture;   // register the compare flags against the request key
    logic sgn;       // keys ordered as two's complement
    logic ins_op;    // open a gap at the lower bound and place the new pair
    logic rem_op;    // close the gap at the matching entry
    logic rep_op;    // overwrite the value of the matching entry
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/skv_cell.sv =====
// One slot of the sorted row: holds a pair, compares it and shifts towards a neighbour.
`default_nettype none
module skv_cell import skv_pkg::*; #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic                  live,
  input  wire logic [KEY_BITS-1:0]   req_key,
  input  wire logic [VALUE_BITS-1:0] req_value,
  input  wire logic                  left_lt,
  input  wire logic [KEY_BITS-1:0]   left_key,
  input  wire logic [VALUE_BITS-1:0] left_value,
  input  wire logic [KEY_BITS-1:0]   right_key,
  input  wire logic [VALUE_BITS-1:0] right_value,
  output logic                       lt,
  output logic                       eq,
  output logic [KEY_BITS-1:0]        cell_key,
  output logic [VALUE_BITS-1:0]      cell_value
);

  logic [KEY_BITS-1:0]   own_rank;
  logic [KEY_BITS-1:0]   req_rank;
  logic [KEY_BITS-1:0]   cell_key_next;
  logic [VALUE_BITS-1:0] cell_value_next;

  // Flipping the sign bit makes unsigned order match two's complement order.
  assign own_rank = {cell_key[KEY_BITS-1] ^ ctrl.sgn, cell_key[KEY_BITS-2:0]};
  assign req_rank = {req_key[KEY_BITS-1] ^ ctrl.sgn, req_key[KEY_BITS-2:0]};

  always_comb begin
    cell_key_next   = cell_key;
    cell_value_next = cell_value;
    if (ctrl.ins_op && !lt) begin
      // The first cell not below the key takes the new pair; those after it move up.
      if (left_lt) begin
        cell_key_next   = req_key;
        cell_value_next = req_value;
      end else begin
        cell_key_next   = left_key;
        cell_value_next = left_value;
      end
    end else if (ctrl.rem_op && !lt) begin
      cell_key_next   = right_key;
      cell_value_next = right_value;
    end else if (ctrl.rep_op && eq) begin
      cell_value_next = req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      lt <= live && (own_rank < req_rank);
      eq <= live && (cell_key == req_key);
    end
    cell_key   <= cell_key_next;
    cell_value <= cell_value_next;
  end

endmodule
`default_nettype wire

// ===== rtl/sorted_key_value_table.sv =====
// Top level of the sorted key/value table: controller, row of cells and result register.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   in       | in_valid / in_stall  | operation, key, value
//   out      | out_valid / out_stall| found, value_out, table_full, entry_count
//   cfg      | cfg_write            | cfg_data (key_signed)
//
// At acceptance all cells compare their key with the request key at once; in the
// update state that follows, the row shifts by one place and the result is registered.
// No new request is taken until the update state ends, and a stalled result holds the
// update state until the output register is free.
// Reset is synchronous and empties the table; a change of key ordering empties it too.
`default_nettype none
module sorted_key_value_table import skv_pkg::*; #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] key,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [31:0]      value_out,
  output logic             table_full,
  output logic [8:0]       entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_t                state, state_next;
  op_t                   op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  key_signed;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  accept;
  logic                  finish;
  logic                  hit;
  logic                  full;
  logic [VALUE_BITS-1:0] hit_value;
  logic [KEY_BITS-1:0]   req_key;
  cell_ctrl_t            ctrl;

  logic [CAPACITY-1:0]   lt_vec;
  logic [CAPACITY-1:0]   eq_vec;
  logic [KEY_BITS-1:0]   key_arr   [CAPACITY];
  logic [VALUE_BITS-1:0] value_arr [CAPACITY];

  assign accept  = in_valid && !in_stall;
  assign req_key = (state == S_IDLE) ? KEY_BITS'(key) : key_q;
  assign full    = (count == CW'(CAPACITY));

  // Only one cell can match, so an OR over the masked values picks it out.
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | eq_vec[i];
      hit_value = hit_value | (eq_vec[i] ? value_arr[i] : '0);
    end
  end

  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    finish       = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.sgn     = key_signed;
    ctrl.ins_op  = 1'b0;
    ctrl.rem_op  = 1'b0;
    ctrl.rep_op  = 1'b0;
    count_next   = count;
    unique case (state)
      S_IDLE: begin
        in_stall     = 1'b0;
        ctrl.capture = in_valid;
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!(out_valid && out_stall)) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          unique case (op_q)
            OP_GET: begin
            end
            OP_INSERT: begin
              ctrl.rep_op = hit;
              ctrl.ins_op = !hit && !full;
              if (!hit && !full) begin
                count_next = count + 1'b1;
              end
            end
            OP_REMOVE: begin
              ctrl.rem_op = hit;
              if (hit) begin
                count_next = count - 1'b1;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(operation);
      key_q   <= KEY_BITS'(key);
      value_q <= VALUE_BITS'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_signed <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write && (cfg_data != key_signed)) begin
        key_signed <= cfg_data;
        count      <= '0;
      end else begin
        count <= count_next;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      found       <= (op_q != OP_CLEAR) && hit;
      value_out   <= (op_q == OP_GET && hit) ? 32'(hit_value) : '0;
      table_full  <= (op_q == OP_INSERT) && !hit && full;
      entry_count <= 9'(count_next);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  left_lt;
    logic [KEY_BITS-1:0]   left_key;
    logic [VALUE_BITS-1:0] left_value;
    logic [KEY_BITS-1:0]   right_key;
    logic [VALUE_BITS-1:0] right_value;

    if (i == 0) begin : g_first
      // The front of the row is where a key below every stored key goes.
      assign left_lt    = 1'b1;
      assign left_key   = key_q;
      assign left_value = value_q;
    end else begin : g_inner
      assign left_lt    = lt_vec[i-1];
      assign left_key   = key_arr[i-1];
      assign left_value = value_arr[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key   = key_arr[i];
      assign right_value = value_arr[i];
    end else begin : g_body
      assign right_key   = key_arr[i+1];
      assign right_value = value_arr[i+1];
    end

    skv_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .live        (count > CW'(i)),
      .req_key     (req_key),
      .req_value   (value_q),
      .left_lt     (left_lt),
      .left_key    (left_key),
      .left_value  (left_value),
      .right_key   (right_key),
      .right_value (right_value),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i]),
      .cell_key    (key_arr[i]),
      .cell_value  (value_arr[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> $onehot0(eq_vec))
    else $error("more than one stored key matches the request");

  a_sorted_prefix: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> (lt_vec & ~{lt_vec[CAPACITY-2:0], 1'b1}) == '0)
    else $error("entries below the request key do not form a prefix");

  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("finished request produced no result");

  a_full_excludes_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && table_full))
    else $error("result reports both a hit and a refused insert");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sorted key/value table with a transaction-level table predictor.
`timescale 1ns / 1ps
module tb_top;
  import skv_pkg::*;

  localparam int CAPACITY    = 256;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic        table_full;
    logic [8:0]  entry_count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = OP_GET;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [31:0] value_out;
  logic        table_full;
  logic [8:0]  entry_count;

  // Predictor state: the table as the block should hold it.
  logic [31:0] tbl_key [CAPACITY];
  logic [31:0] tbl_val [CAPACITY];
  int          tbl_count = 0;
  logic        signed_order = 1'b0;

  table_result_t pending_results [$];
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            send_gap_max = 15;
  int            stall_max = 15;
  int            hold_request = 0;
  logic [31:0]   key_pool [40];

  sorted_key_value_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .value_out   (value_out),
    .table_full  (table_full),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] key_rank(logic [31:0] k);
    return signed_order ? (k ^ 32'h8000_0000) : k;
  endfunction

  function automatic table_result_t apply_table_op(op_t op, logic [31:0] k, logic [31:0] v);
    table_result_t res;
    int            pos;
    logic          hit;
    res = '0;
    pos = 0;
    hit = 1'b0;
    if (op != OP_CLEAR) begin
      while (pos < tbl_count && key_rank(tbl_key[pos]) < key_rank(k)) pos++;
      hit = (pos < tbl_count) && (tbl_key[pos] == k);
    end
    res.found = hit;
    case (op)
      OP_GET: begin
        if (hit) res.value_out = tbl_val[pos];
      end
      OP_INSERT: begin
        if (hit) begin
          tbl_val[pos] = v;
        end else if (tbl_count >= CAPACITY) begin
          res.table_full = 1'b1;
        end else begin
          for (int i = tbl_count; i > pos; i--) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_val[i] = tbl_val[i-1];
          end
          tbl_key[pos] = k;
          tbl_val[pos] = v;
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_val[i] = tbl_val[i+1];
          end
          tbl_count--;
        end
      end
      default: tbl_count = 0;
    endcase
    res.entry_count = 9'(tbl_count);
    return res;
  endfunction

  // Receiver: a fresh wait is drawn after each accepted result; a hold request overrides it.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (out_valid && !out_stall) begin
        stall_left = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    table_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (found !== exp_res.found) begin
          $error("found: expected %0d, got %0d", exp_res.found, found);
          mismatch_count++;
        end
        if (value_out !== exp_res.value_out) begin
          $error("value_out: expected %h, got %h", exp_res.value_out, value_out);
          mismatch_count++;
        end
        if (table_full !== exp_res.table_full) begin
          $error("table_full: expected %0d, got %0d", exp_res.table_full, table_full);
          mismatch_count++;
        end
        if (entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.entry_count, entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Called at a clock edge; returns at the edge where the request was accepted.
  task automatic send_request(op_t op, logic [31:0] k, logic [31:0] v);
    int gap;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    value     <= v;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_table_op(op, k, v));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key_order(logic signed_keys);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= signed_keys;
    @(posedge clk);
    cfg_write <= 1'b0;
    // A change of ordering empties the table; rewriting the same value leaves it alone.
    if (signed_keys != signed_order) begin
      signed_order = signed_keys;
      tbl_count = 0;
    end
  endtask

  task automatic test_basic_ops();
    send_request(OP_GET, 32'd5, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'd5, 32'h0);
    send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000, 32'h1234_5678);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'hA5A5_5A5A);
    send_request(OP_INSERT, 32'd5, 32'h0000_0001);
    send_request(OP_INSERT, 32'd5, 32'h8000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_GET, 32'd5, 32'h0);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    send_request(OP_REMOVE, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'h0000_0000, 32'h0);
    wait_idle();
  endtask

  task automatic test_key_order();
    send_request(OP_INSERT, 32'd3, 32'hDEAD_BEEF);
    write_key_order(1'b0);
    send_request(OP_GET, 32'd3, 32'h0);
    write_key_order(1'b1);
    send_request(OP_GET, 32'd3, 32'h0);
    send_request(OP_INSERT, 32'h8000_0000, 32'h1111_1111);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h2222_2222);
    send_request(OP_INSERT, 32'h0000_0000, 32'h3333_3333);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'h4444_4444);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_GET, 32'h8000_0000, 32'h0);
    wait_idle();
  endtask

  task automatic test_full_table();
    int          order [CAPACITY];
    logic [23:0] low_bits [CAPACITY];
    int          j;
    int          tmp;
    logic [31:0] k;
    for (int i = 0; i < CAPACITY; i++) begin
      order[i] = i;
      low_bits[i] = 24'($urandom);
    end
    for (int i = CAPACITY - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_request(OP_CLEAR, 32'h0, 32'h0);
    // The top byte keeps every key distinct; the insert order is shuffled.
    for (int i = 0; i < CAPACITY; i++) begin
      send_request(OP_INSERT, {8'(order[i]), low_bits[order[i]]}, $urandom);
    end
    k = {8'(order[7]), low_bits[order[7]] ^ 24'h1};
    send_request(OP_INSERT, k, $urandom);
    send_request(OP_INSERT, {8'(order[9]), low_bits[order[9]]}, $urandom);
    send_request(OP_GET, {8'(order[9]), low_bits[order[9]]}, 32'h0);
    send_request(OP_REMOVE, {8'(order[3]), low_bits[order[3]]}, 32'h0);
    send_request(OP_INSERT, k, $urandom);
    send_request(OP_GET, k, 32'h0);
    send_request(OP_INSERT, {8'(order[3]), low_bits[order[3]]}, $urandom);
    send_request(OP_CLEAR, 32'h0, 32'h0);
    wait_idle();
  endtask

  task automatic send_random_request();
    int          pick;
    op_t         op;
    logic [31:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_INSERT;
    else if (pick < 75) op = OP_GET;
    else if (pick < 97) op = OP_REMOVE;
    else op = OP_CLEAR;
    k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 39)] : $urandom;
    send_request(op, k, $urandom);
  endtask

  task automatic test_backpressure();
    hold_request = 300;
    send_gap_max = 0;
    for (int i = 0; i < 40; i++) send_random_request();
    // The sender now holds back until every result has drained.
    wait_idle();
    send_gap_max = 15;
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_random_request();
    wait_idle();
  endtask

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'hFFFF_FFFF;
    key_pool[5] = 32'hFFFF_FFFE;
    for (int i = 6; i < 40; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_key_order();
    test_full_table();
    test_backpressure();
    test_random(90);
    write_key_order(1'b0);
    send_gap_max = 0;
    stall_max = 0;
    test_random(90);
    send_gap_max = 15;
    stall_max = 15;
    write_key_order(1'b1);
    test_random(90);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
